// ===== hdl/btpc_pkg.sv =====
`default_nettype none
package btpc_pkg;

	// Width of the pressure divider and of the pressure datapath.
	localparam int unsigned DIV_W = 64;
	// Number of cells in the divider chain, one quotient bit each.
	localparam int unsigned DIV_CELLS = DIV_W;

	localparam logic signed [33:0] FINE_OFFSET = 34'sd128000;
	localparam logic [20:0] P_FULL_SCALE = 21'd1048576;
	localparam logic [63:0] P_SCALE = 64'd3125;
	localparam logic [63:0] V1_BIAS = 64'd140737488355328;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		CFG_T1    = 3'd0,
		CFG_T2    = 3'd1,
		CFG_T3    = 3'd2,
		CFG_P1    = 3'd3,
		CFG_P2_P3 = 3'd4,
		CFG_P4_P5 = 3'd5,
		CFG_P6_P7 = 3'd6,
		CFG_P8_P9 = 3'd7
	} cfg_index_t;

	// Sideband that rides along the divider chain.
	typedef struct packed {
		logic        neg;
		logic        invalid;
		logic [23:0] temperature_centi;
		logic [19:0] unused_pad;
	} div_side_t;

	// Working word of one divider cell.
	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [DIV_W-1:0] quo;
		logic [DIV_W-1:0] md;
		div_side_t        side;
	} div_word_t;

endpackage
`default_nettype wire

// ===== hdl/baro_temp_pressure_compensation.sv =====
`default_nettype none
// Barometric temperature and pressure compensation.
// The input stream (s_tvalid, s_tready, s_tdata) carries one pair of raw 20-bit
// converter readings per transfer. The output stream (m_tvalid, m_tready, m_tdata,
// m_tuser) carries one result per input transfer, in the same order: temperature
// in hundredths of a degree, pressure in Pa as Q24.8, and an invalid flag in tuser
// that is set when the pressure divisor came out zero (pressure then reads 0).
// The calibration words are written through the cfg channel, which is always
// ready; they must only change while no reading is in flight.
// The datapath is a single stall-controlled pipeline, so one reading is taken
// every cycle while s_tready is high; most of its stages are the 64-cell divider
// chain, one quotient bit a cell.
// When the receiver holds m_tready low with a result waiting, a skid register
// behind the output register catches the one result still moving; only then does
// the whole pipeline freeze, and s_tready stays low until the output is taken.
// s_tready is driven from a register, so it never follows m_tready in the same
// cycle. No data is lost.
// Reset clears all stage valid flags and the calibration words to zero.
module baro_temp_pressure_compensation (
	input  wire         clk,
	input  wire         arst_n,
	// Configuration write channel.
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [31:0] cfg_data,
	// Input stream.
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
	// Output stream.
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [55:0] m_tdata,   // temperature_centi[23:0], pressure_q24_8[55:24]
	output logic [0:0]  m_tuser    // pressure_invalid[0]
);

	// Calibration registers.
	logic [15:0] coef_t1_q, coef_t2_q, coef_t3_q, coef_p1_q;
	logic [31:0] coef_p23_q, coef_p45_q, coef_p67_q, coef_p89_q;

	// Pipeline advance: everything moves unless the skid register is occupied.
	logic adv;
	// The output register can take a new result at this edge.
	logic out_free;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_s10, v_s11, v_s12, v_out_q;

	// Stage 1: first products of the fine temperature.
	logic [31:0] e1_c, d_c;
	logic [31:0] a1_s1, dd_s1;
	logic [19:0] adc_t_s1;
	logic [19:0] adc_p_s1, adc_p_s2, adc_p_s3, adc_p_s4, adc_p_s5, adc_p_s6;

	// Stage 2 and 3: fine temperature.
	logic [31:0] ddsh_c;
	logic [31:0] a_s2, b1_s2;
	logic [31:0] fine_s3;

	// Stage 4: temperature output and the square of the offset temperature.
	logic signed [35:0] wide_c, tw_c;
	logic signed [33:0] x_c;
	logic [23:0] tc_s4, tc_s5, tc_s6, tc_s7, tc_s8;
	logic signed [63:0] xx_s4, xp5_s4, xp2_s4;

	// Stage 5 to 8: polynomial terms, divisor and dividend.
	logic signed [63:0] v2a_s5, v1a_s5, xp5_s5, xp2_s5;
	logic signed [63:0] p4_c;
	logic signed [63:0] v2_s6;
	logic [63:0] v1_s6;
	logic [20:0] pcomp_c;
	logic [63:0] v1p_s7, pd_s7;
	logic [63:0] dv_s8, num_s8;

	// Stage 9: divider entry.
	btpc_pkg::div_word_t div_in_s9, div_out;
	logic div_vld;

	// Stage 10 to 12: polynomial on the quotient.
	logic [63:0] q_c;
	logic [63:0] p_s10, p_s11, p_s12;
	logic inv_s10, inv_s11, inv_s12;
	logic [23:0] tc_s10, tc_s11, tc_s12;
	logic [63:0] sq_c;
	logic [31:0] cross_c;
	logic [63:0] qq_s11;
	logic signed [63:0] p8p_s11, v1b_s12, v2b_s12;

	// Output stage and skid register.
	logic signed [63:0] sum_c, res_c, p7_c;
	logic [31:0] res_p_c;
	logic [23:0] out_tc_q;
	logic [31:0] out_p_q;
	logic        out_inv_q;
	logic        sk_vld_q;
	logic [23:0] sk_tc_q;
	logic [31:0] sk_p_q;
	logic        sk_inv_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_t1_q  <= '0;
			coef_t2_q  <= '0;
			coef_t3_q  <= '0;
			coef_p1_q  <= '0;
			coef_p23_q <= '0;
			coef_p45_q <= '0;
			coef_p67_q <= '0;
			coef_p89_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (btpc_pkg::cfg_index_t'(cfg_index))
				btpc_pkg::CFG_T1:    coef_t1_q  <= cfg_data[15:0];
				btpc_pkg::CFG_T2:    coef_t2_q  <= cfg_data[15:0];
				btpc_pkg::CFG_T3:    coef_t3_q  <= cfg_data[15:0];
				btpc_pkg::CFG_P1:    coef_p1_q  <= cfg_data[15:0];
				btpc_pkg::CFG_P2_P3: coef_p23_q <= cfg_data;
				btpc_pkg::CFG_P4_P5: coef_p45_q <= cfg_data;
				btpc_pkg::CFG_P6_P7: coef_p67_q <= cfg_data;
				btpc_pkg::CFG_P8_P9: coef_p89_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !v_out_q || m_tready;
	assign adv      = !sk_vld_q;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			v_out_q <= 1'b0;
			sk_vld_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
			v_s9 <= v_s8; v_s10 <= div_vld; v_s11 <= v_s10; v_s12 <= v_s11;
			// A result that meets a held output waits in the skid register.
			if (out_free) begin
				v_out_q <= v_s12;
			end else if (v_s12) begin
				sk_vld_q <= 1'b1;
			end
		end else if (m_tready) begin
			// The output was taken; the skid result moves up and the pipeline resumes.
			sk_vld_q <= 1'b0;
		end
	end

	// Fine temperature, all arithmetic wraps at 32 bits.
	assign e1_c   = {15'd0, s_tdata[19:3]} - {15'd0, coef_t1_q, 1'b0};
	assign d_c    = {16'd0, s_tdata[19:4]} - {16'd0, coef_t1_q};
	assign ddsh_c = 32'($signed(dd_s1) >>> 12);

	// Temperature is formed wide and then clamped to 24 bits.
	assign wide_c = $signed({{4{fine_s3[31]}}, fine_s3}) * 36'sd5 + 36'sd128;
	assign tw_c   = wide_c >>> 8;
	assign x_c    = $signed({{2{fine_s3[31]}}, fine_s3}) - btpc_pkg::FINE_OFFSET;

	assign p4_c    = 64'($signed(coef_p45_q[15:0]));
	assign pcomp_c = btpc_pkg::P_FULL_SCALE - {1'b0, adc_p_s6};

	// The divider works on magnitudes; the sign is restored at its end.
	assign q_c = div_out.side.neg ? (64'd0 - div_out.quo) : div_out.quo;

	// Low 64 bits of the square, from two 32-bit partial products.
	assign sq_c    = 64'($signed(p_s10) >>> 13);
	assign cross_c = sq_c[63:32] * sq_c[31:0];

	assign p7_c    = 64'($signed(coef_p67_q[31:16]));
	assign sum_c   = $signed(p_s12) + (v1b_s12 >>> 25) + v2b_s12;
	assign res_c   = (sum_c >>> 8) + (p7_c <<< 4);
	assign res_p_c = inv_s12 ? 32'd0 : res_c[31:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1
			a1_s1    <= e1_c * {{16{coef_t2_q[15]}}, coef_t2_q};
			dd_s1    <= d_c * d_c;
			adc_t_s1 <= s_tdata[19:0];
			adc_p_s1 <= s_tdata[39:20];
			// Stage 2
			a_s2     <= 32'($signed(a1_s1) >>> 11);
			b1_s2    <= ddsh_c * {{16{coef_t3_q[15]}}, coef_t3_q};
			adc_p_s2 <= adc_p_s1;
			// Stage 3
			fine_s3  <= a_s2 + 32'($signed(b1_s2) >>> 14);
			adc_p_s3 <= adc_p_s2;
			// Stage 4
			if (tw_c > 36'sd8388607) begin
				tc_s4 <= 24'h7FFFFF;
			end else if (tw_c < -36'sd8388608) begin
				tc_s4 <= 24'h800000;
			end else begin
				tc_s4 <= tw_c[23:0];
			end
			xx_s4    <= x_c * x_c;
			xp5_s4   <= x_c * $signed(coef_p45_q[31:16]);
			xp2_s4   <= x_c * $signed(coef_p23_q[15:0]);
			adc_p_s4 <= adc_p_s3;
			// Stage 5
			v2a_s5   <= xx_s4 * $signed(coef_p67_q[15:0]);
			v1a_s5   <= xx_s4 * $signed(coef_p23_q[31:16]);
			xp5_s5   <= xp5_s4;
			xp2_s5   <= xp2_s4;
			tc_s5    <= tc_s4;
			adc_p_s5 <= adc_p_s4;
			// Stage 6
			v2_s6    <= v2a_s5 + (xp5_s5 <<< 17) + (p4_c <<< 35);
			v1_s6    <= 64'((v1a_s5 >>> 8) + (xp2_s5 <<< 12)) + btpc_pkg::V1_BIAS;
			tc_s6    <= tc_s5;
			adc_p_s6 <= adc_p_s5;
			// Stage 7
			v1p_s7   <= v1_s6 * {48'd0, coef_p1_q};
			pd_s7    <= ({43'd0, pcomp_c} << 31) - 64'(v2_s6);
			tc_s7    <= tc_s6;
			// Stage 8
			dv_s8    <= 64'($signed(v1p_s7) >>> 33);
			num_s8   <= pd_s7 * btpc_pkg::P_SCALE;
			tc_s8    <= tc_s7;
			// Stage 9
			div_in_s9.rem <= '0;
			div_in_s9.quo <= num_s8[63] ? (64'd0 - num_s8) : num_s8;
			div_in_s9.md  <= dv_s8[63] ? (64'd0 - dv_s8) : dv_s8;
			div_in_s9.side.neg               <= num_s8[63] ^ dv_s8[63];
			div_in_s9.side.invalid           <= (dv_s8 == 64'd0);
			div_in_s9.side.temperature_centi <= tc_s8;
			div_in_s9.side.unused_pad        <= adc_t_s1;
			// Stage 10
			p_s10    <= q_c;
			inv_s10  <= div_out.side.invalid;
			tc_s10   <= div_out.side.temperature_centi;
			// Stage 11
			qq_s11   <= ({32'd0, sq_c[31:0]} * {32'd0, sq_c[31:0]}) + {cross_c[30:0], 33'd0};
			p8p_s11  <= $signed(p_s10) * $signed(coef_p89_q[15:0]);
			p_s11    <= p_s10;
			inv_s11  <= inv_s10;
			tc_s11   <= tc_s10;
			// Stage 12
			v1b_s12  <= $signed(qq_s11) * $signed(coef_p89_q[31:16]);
			v2b_s12  <= p8p_s11 >>> 19;
			p_s12    <= p_s11;
			inv_s12  <= inv_s11;
			tc_s12   <= tc_s11;
		end
	end

	// Output register, fed from the last stage or from the skid register.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (out_free) begin
				out_tc_q  <= tc_s12;
				out_p_q   <= res_p_c;
				out_inv_q <= inv_s12;
			end else begin
				sk_tc_q  <= tc_s12;
				sk_p_q   <= res_p_c;
				sk_inv_q <= inv_s12;
			end
		end else if (m_tready) begin
			out_tc_q  <= sk_tc_q;
			out_p_q   <= sk_p_q;
			out_inv_q <= sk_inv_q;
		end
	end

	btpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.in_vld (v_s9),
		.in_w   (div_in_s9),
		.out_vld(div_vld),
		.out_w  (div_out)
	);

	assign m_tvalid   = v_out_q;
	assign m_tdata    = {out_p_q, out_tc_q};
	assign m_tuser[0] = out_inv_q;

	// A result flagged invalid always carries zero pressure.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[55:24] == 32'd0)
		else $error("invalid result with nonzero pressure");

	// Input is only held off while a result is waiting at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input held off with no result waiting");

	// An output result that the receiver holds off stays unchanged for the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule
`default_nettype wire

// ===== hdl/btpc_div_cell.sv =====
`default_nettype none
module btpc_div_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wire                 in_vld,
	input  btpc_pkg::div_word_t in_w,
	output logic                out_vld,
	output btpc_pkg::div_word_t out_w
);

	logic [btpc_pkg::DIV_W:0] shifted;
	logic [btpc_pkg::DIV_W:0] diff;
	logic                     vld_q;
	btpc_pkg::div_word_t      word_q;

	// One restoring step: bring down the next dividend bit and try the divisor.
	assign shifted = {in_w.rem, in_w.quo[btpc_pkg::DIV_W-1]};
	assign diff    = shifted - {1'b0, in_w.md};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q.md   <= in_w.md;
			word_q.side <= in_w.side;
			if (!diff[btpc_pkg::DIV_W]) begin
				word_q.rem <= diff[btpc_pkg::DIV_W-1:0];
				word_q.quo <= {in_w.quo[btpc_pkg::DIV_W-2:0], 1'b1};
			end else begin
				word_q.rem <= shifted[btpc_pkg::DIV_W-1:0];
				word_q.quo <= {in_w.quo[btpc_pkg::DIV_W-2:0], 1'b0};
			end
		end
	end

	assign out_vld = vld_q;
	assign out_w   = word_q;

endmodule
`default_nettype wire

// ===== hdl/btpc_div.sv =====
`default_nettype none
module btpc_div (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wire                 in_vld,
	input  btpc_pkg::div_word_t in_w,
	output logic                out_vld,
	output btpc_pkg::div_word_t out_w
);

	logic                vld_chain [0:btpc_pkg::DIV_CELLS];
	btpc_pkg::div_word_t w_chain   [0:btpc_pkg::DIV_CELLS];

	assign vld_chain[0] = in_vld;
	assign w_chain[0]   = in_w;

	// Each cell resolves one quotient bit, most significant first.
	for (genvar i = 0; i < btpc_pkg::DIV_CELLS; i++) begin : g_cell
		btpc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_vld (vld_chain[i]),
			.in_w   (w_chain[i]),
			.out_vld(vld_chain[i+1]),
			.out_w  (w_chain[i+1])
		);
	end

	assign out_vld = vld_chain[btpc_pkg::DIV_CELLS];
	assign out_w   = w_chain[btpc_pkg::DIV_CELLS];

endmodule
`default_nettype wire
